// ===== rtl/ycc_pkg.sv =====
// ----------------------------------------------------------------------------
// ycc_pkg
// Shared types, constants and color-math functions of the RGB to YCbCr 4:2:0
// converter.
// ----------------------------------------------------------------------------
package ycc_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int PIX_W  = 8;            // one color component
  localparam int SUM_W  = PIX_W + 1;    // sum of two components
  localparam int SIZE_W = 13;           // frame size registers
  localparam int POS_W  = SIZE_W + 1;   // position math with headroom
  localparam int ADDR_W = 3;
  localparam int APB_DW = 32;

  localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = SIZE_W'(480);

  // register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } ycc_reg_t;

  // effective frame size handed from the register block
  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } ycc_size_t;

  // horizontal pair sums of one 2x1 pixel pair
  typedef struct packed {
    logic [SUM_W-1:0] b;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] r;
  } ycc_pair_t;

  // BT.601 studio-swing coefficients
  localparam logic [16:0] Y_KR = 17'd66;
  localparam logic [16:0] Y_KG = 17'd129;
  localparam logic [16:0] Y_KB = 17'd25;
  localparam logic [16:0] Y_RND = 17'd128;
  localparam logic [PIX_W-1:0] Y_OFS = 8'd16;

  localparam logic signed [17:0] CB_KR = -18'sd38;
  localparam logic signed [17:0] CB_KG = -18'sd74;
  localparam logic signed [17:0] CB_KB = 18'sd112;
  localparam logic signed [17:0] CR_KR = 18'sd112;
  localparam logic signed [17:0] CR_KG = -18'sd94;
  localparam logic signed [17:0] CR_KB = -18'sd18;
  localparam logic signed [17:0] C_RND = 18'sd128;
  localparam logic signed [17:0] C_OFS = 18'sd128;

  // Luma of one pixel; the result tops out at 235, so no clamp is needed.
  function automatic logic [PIX_W-1:0] luma_of(input logic [PIX_W-1:0] r,
                                               input logic [PIX_W-1:0] g,
                                               input logic [PIX_W-1:0] b);
    logic [16:0] acc;
    acc = Y_KR * 17'(r) + Y_KG * 17'(g) + Y_KB * 17'(b) + Y_RND;
    return PIX_W'(acc[16:8]) + Y_OFS;
  endfunction

  // Floor shift, offset and clamp to a byte.
  function automatic logic [PIX_W-1:0] chroma_clamp(input logic signed [17:0] acc);
    logic signed [17:0] t;
    t = (acc >>> 8) + C_OFS;
    if (t < 0) begin
      return '0;
    end else if (t > 18'sd255) begin
      return 8'd255;
    end else begin
      return PIX_W'(t);
    end
  endfunction

  function automatic logic [PIX_W-1:0] cb_of(input logic [PIX_W-1:0] r,
                                             input logic [PIX_W-1:0] g,
                                             input logic [PIX_W-1:0] b);
    logic signed [17:0] acc;
    acc = CB_KR * $signed(18'(r)) + CB_KG * $signed(18'(g))
        + CB_KB * $signed(18'(b)) + C_RND;
    return chroma_clamp(acc);
  endfunction

  function automatic logic [PIX_W-1:0] cr_of(input logic [PIX_W-1:0] r,
                                             input logic [PIX_W-1:0] g,
                                             input logic [PIX_W-1:0] b);
    logic signed [17:0] acc;
    acc = CR_KR * $signed(18'(r)) + CR_KG * $signed(18'(g))
        + CR_KB * $signed(18'(b)) + C_RND;
    return chroma_clamp(acc);
  endfunction

  // Rounded four-pixel average from two pair sums.
  function automatic logic [PIX_W-1:0] avg4(input logic [SUM_W-1:0] a,
                                            input logic [SUM_W-1:0] c);
    logic [SUM_W+1:0] s;
    s = (SUM_W+2)'(a) + (SUM_W+2)'(c) + (SUM_W+2)'(2);
    return PIX_W'(s >> 2);
  endfunction

endpackage

// ===== rtl/ycc_pix_if.sv =====
// ----------------------------------------------------------------------------
// ycc_pix_if
// Input pixel channel: valid/ready with blue, green and red components.
// ----------------------------------------------------------------------------
interface ycc_pix_if
  import ycc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blue;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] red;

  modport source (output valid, output blue, output green, output red, input ready);
  modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

// ===== rtl/ycc_out_if.sv =====
// ----------------------------------------------------------------------------
// ycc_out_if
// Result channel: valid/ready with luma, block chroma and frame end flag.
// ----------------------------------------------------------------------------
interface ycc_out_if
  import ycc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] luma;
  logic             chroma_valid;
  logic [PIX_W-1:0] cb;
  logic [PIX_W-1:0] cr;
  logic             frame_end;

  modport source (output valid, output luma, output chroma_valid, output cb,
                  output cr, output frame_end, input ready);
  modport sink   (input valid, input luma, input chroma_valid, input cb,
                  input cr, input frame_end, output ready);
endinterface

// ===== rtl/ycc_regs.sv =====
// ----------------------------------------------------------------------------
// ycc_regs
// APB register block for frame width and height; derives the effective size.
// ----------------------------------------------------------------------------
module ycc_regs
  import ycc_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output ycc_size_t         size
);

  localparam logic [POS_W-1:0] MW = POS_W'(MAX_WIDTH & ~1);
  localparam logic [POS_W-1:0] MH = POS_W'(MAX_HEIGHT & ~1);

  logic [SIZE_W-1:0] width_r,  width_nxt;
  logic [SIZE_W-1:0] height_r, height_nxt;
  logic              wr_en;
  ycc_reg_t          reg_sel;

  // clear the low bit, lift zero to two, saturate at the even maximum
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                 input logic [POS_W-1:0] m);
    logic [POS_W-1:0] e;
    e = {1'b0, v[SIZE_W-1:1], 1'b0};
    if (e == '0) begin
      e = POS_W'(2);
    end
    if (e > m) begin
      e = m;
    end
    return SIZE_W'(e);
  endfunction

  assign pready  = 1'b1;
  assign reg_sel = ycc_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      case (reg_sel)
        REG_FRAME_WIDTH:  width_nxt  = pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT: height_nxt = pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_FRAME_WIDTH;
      height_r <= RST_FRAME_HEIGHT;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAME_WIDTH:  prdata = APB_DW'(width_r);
      REG_FRAME_HEIGHT: prdata = APB_DW'(height_r);
      default:          prdata = '0;
    endcase
  end

  assign size.width  = eff_size(width_r, MW);
  assign size.height = eff_size(height_r, MH);

endmodule

// ===== rtl/ycc_line_mem.sv =====
// ----------------------------------------------------------------------------
// ycc_line_mem
// Line buffer of pair sums: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ycc_line_mem
  import ycc_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_WIDTH / 2,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  ycc_pair_t         wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output ycc_pair_t         rd_data
);

  ycc_pair_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/rgb_to_ycbcr420_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_ycbcr420_converter
// Raster-order RGB pixels in, BT.601 luma per pixel and 4:2:0 chroma per 2x2
// block out, with a line buffer of horizontal pair sums.
// ----------------------------------------------------------------------------
// An accepted pixel moves through the stage 1, stage 2 and stage 3 registers to its result item.
// Throughput: one item per cycle while out_ycc.ready holds; the line buffer takes one write or one read
//   per item, so the single memory port pair sets no further limit.
// Reset (rst_n low, synchronous): counters, held pixel and stage valids clear,
//   size registers return to 640 x 480; the line buffer is not cleared.
// ----------------------------------------------------------------------------
module rgb_to_ycbcr420_converter
  import ycc_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  ycc_pix_if.sink           in_pix,
  ycc_out_if.source         out_ycc,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W      = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LA_W       = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  ycc_size_t size;

  // raster position and held even-column pixel
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [PIX_W-1:0] hb_r, hg_r, hr_r;

  // stage 1: luma done, pair sums and line-buffer read in flight
  logic             v1_r;
  logic [PIX_W-1:0] s1_luma_r;
  logic             s1_chroma_r;
  logic             s1_fend_r;
  ycc_pair_t        s1_pair_r;

  // stage 2: four-pixel averages
  logic             v2_r;
  logic [PIX_W-1:0] s2_luma_r;
  logic             s2_chroma_r;
  logic             s2_fend_r;
  logic [PIX_W-1:0] s2_ab_r, s2_ag_r, s2_ar_r;

  // stage 3: output register
  logic             v3_r;
  logic [PIX_W-1:0] s3_luma_r;
  logic             s3_chroma_r;
  logic             s3_fend_r;
  logic [PIX_W-1:0] s3_cb_r, s3_cr_r;

  logic adv1, adv2, adv3;
  logic accept;

  // position math, all at POS_W bits
  logic [POS_W-1:0] w_e, h_e;
  logic [POS_W-1:0] col_in, row_in, row_bump;
  logic [POS_W-1:0] col_cur, row_cur;
  logic             last_col, last_row;
  logic             odd_col, odd_row;
  logic             fend;
  ycc_pair_t        pair;
  ycc_pair_t        line_rd;
  logic             line_wr_en, line_rd_en;
  logic [LA_W-1:0]  line_addr;

  ycc_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .size    (size)
  );

  // Stall chain: a stage advances when it is empty or the next one moves,
  // so bubbles fill while a finished item waits at the output.
  assign adv3         = !v3_r || out_ycc.ready;
  assign adv2         = !v2_r || adv3;
  assign adv1         = !v1_r || adv2;
  assign in_pix.ready = adv1;
  assign accept       = in_pix.valid && adv1;

  // Place the pixel. A size change mid-frame can leave the counters outside
  // the frame: past the row end starts the next row, past the last row
  // starts row zero.
  always_comb begin
    w_e      = POS_W'(size.width);
    h_e      = POS_W'(size.height);
    col_in   = POS_W'(col_r);
    row_in   = POS_W'(row_r);
    row_bump = row_in + POS_W'(1);
    if (col_in >= w_e) begin
      col_cur = '0;
      row_cur = (row_bump >= h_e) ? '0 : row_bump;
    end else begin
      col_cur = col_in;
      row_cur = (row_in >= h_e) ? '0 : row_in;
    end
    last_col = (col_cur + POS_W'(1)) >= w_e;
    last_row = (row_cur + POS_W'(1)) >= h_e;
    odd_col  = col_cur[0];
    odd_row  = row_cur[0];
    fend     = last_col && last_row;

    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : ROW_W'(row_cur + POS_W'(1));
    end else begin
      col_nxt = COL_W'(col_cur + POS_W'(1));
      row_nxt = ROW_W'(row_cur);
    end

    pair.b = SUM_W'(hb_r) + SUM_W'(in_pix.blue);
    pair.g = SUM_W'(hg_r) + SUM_W'(in_pix.green);
    pair.r = SUM_W'(hr_r) + SUM_W'(in_pix.red);
  end

  // Even rows store the pair sums, odd rows fetch them one row later; an
  // entry is never read and written by the same item, and the read trails
  // the write by at least a full row, so no forwarding is needed.
  assign line_addr  = col_cur[LA_W:1];
  assign line_wr_en = accept && odd_col && !odd_row;
  assign line_rd_en = accept && odd_col && odd_row;

  ycc_line_mem #(
    .DEPTH  (LINE_DEPTH),
    .ADDR_W (LA_W)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (line_wr_en),
    .wr_addr (line_addr),
    .wr_data (pair),
    .rd_en   (line_rd_en),
    .rd_addr (line_addr),
    .rd_data (line_rd)
  );

  // counters and held pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      hb_r  <= '0;
      hg_r  <= '0;
      hr_r  <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (!odd_col) begin
        hb_r <= in_pix.blue;
        hg_r <= in_pix.green;
        hr_r <= in_pix.red;
      end
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_pix.valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
    end
  end

  // stage 1: luma and pair sums
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_luma_r   <= luma_of(in_pix.red, in_pix.green, in_pix.blue);
      s1_chroma_r <= odd_col && odd_row;
      s1_fend_r   <= fend;
      s1_pair_r   <= pair;
    end
  end

  // stage 2: combine with the stored row and round to averages
  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      s2_luma_r   <= s1_luma_r;
      s2_chroma_r <= s1_chroma_r;
      s2_fend_r   <= s1_fend_r;
      s2_ab_r     <= avg4(s1_pair_r.b, line_rd.b);
      s2_ag_r     <= avg4(s1_pair_r.g, line_rd.g);
      s2_ar_r     <= avg4(s1_pair_r.r, line_rd.r);
    end
  end

  // stage 3: chroma, zero when the pixel does not close a block
  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      s3_luma_r   <= s2_luma_r;
      s3_chroma_r <= s2_chroma_r;
      s3_fend_r   <= s2_fend_r;
      s3_cb_r     <= s2_chroma_r ? cb_of(s2_ar_r, s2_ag_r, s2_ab_r) : '0;
      s3_cr_r     <= s2_chroma_r ? cr_of(s2_ar_r, s2_ag_r, s2_ab_r) : '0;
    end
  end

  assign out_ycc.valid        = v3_r;
  assign out_ycc.luma         = s3_luma_r;
  assign out_ycc.chroma_valid = s3_chroma_r;
  assign out_ycc.cb           = s3_cb_r;
  assign out_ycc.cr           = s3_cr_r;
  assign out_ycc.frame_end    = s3_fend_r;

endmodule

// ===== tb/rgb_to_ycbcr420_converter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_ycbcr420_converter_checker
// Watches the pixel, result and register ports of the converter, predicts
// luma, 4:2:0 chroma and frame end for every accepted pixel and compares each
// accepted result item with the oldest prediction.
// ----------------------------------------------------------------------------
module rgb_to_ycbcr420_converter_checker
  import ycc_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  ycc_pix_if                pix,
  ycc_out_if                ycc,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  output int                errors,
  output int                pending
);

  localparam int LUMA_R = 66;
  localparam int LUMA_G = 129;
  localparam int LUMA_B = 25;
  localparam int LUMA_OFFSET = 16;
  localparam int CB_R = -38;
  localparam int CB_G = -74;
  localparam int CB_B = 112;
  localparam int CR_R = 112;
  localparam int CR_G = -94;
  localparam int CR_B = -18;
  localparam int HALF_LSB = 128;
  localparam int CHROMA_OFFSET = 128;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic             chroma_valid;
    logic [PIX_W-1:0] cb;
    logic [PIX_W-1:0] cr;
    logic             frame_end;
  } ycc_result_t;

  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  int                col_pos;
  int                row_pos;
  logic [PIX_W-1:0]  held_b;
  logic [PIX_W-1:0]  held_g;
  logic [PIX_W-1:0]  held_r;
  ycc_pair_t         pair_line [MAX_WIDTH/2];
  ycc_result_t       expected_ycc [$];
  int                mismatches = 0;
  int                outstanding = 0;

  assign errors  = mismatches;
  assign pending = outstanding;

  // Even size, zero taken as two, capped at the even part of the limit.
  function automatic int eff_size(input logic [SIZE_W-1:0] raw, input int limit);
    int e;
    e = int'(raw) & ~1;
    if (e == 0) e = 2;
    if (e > (limit & ~1)) e = limit & ~1;
    return e;
  endfunction

  function automatic logic [PIX_W-1:0] sat_byte(input int v);
    if (v < 0) return '0;
    if (v > 255) return 8'd255;
    return PIX_W'(v);
  endfunction

  function automatic logic [PIX_W-1:0] chroma_of(input int kr, input int kg, input int kb,
                                                 input int ar, input int ag, input int ab);
    int acc;
    acc = kr * ar + kg * ag + kb * ab + HALF_LSB;
    return sat_byte((acc >>> 8) + CHROMA_OFFSET);
  endfunction

  // Advance the raster position by one pixel and work out its result item.
  function automatic ycc_result_t convert_pixel(input logic [PIX_W-1:0] b,
                                                input logic [PIX_W-1:0] g,
                                                input logic [PIX_W-1:0] r);
    int               w, h, col, row, idx, ab, ag, ar;
    logic [SUM_W-1:0] sb, sg, sr;
    ycc_result_t      res;
    w = eff_size(width_reg, MAX_WIDTH);
    h = eff_size(height_reg, MAX_HEIGHT);
    col = col_pos;
    row = row_pos;
    if (col >= w) begin
      col = 0;
      row = row + 1;
    end
    if (row >= h) row = 0;
    res = '0;
    res.luma = sat_byte(((LUMA_R * int'(r) + LUMA_G * int'(g) + LUMA_B * int'(b)
                          + HALF_LSB) >> 8) + LUMA_OFFSET);
    if (col % 2 == 0) begin
      held_b = b;
      held_g = g;
      held_r = r;
    end else begin
      sb = {1'b0, held_b} + {1'b0, b};
      sg = {1'b0, held_g} + {1'b0, g};
      sr = {1'b0, held_r} + {1'b0, r};
      idx = col / 2;
      if (row % 2 == 0) begin
        pair_line[idx] = {sb, sg, sr};
      end else begin
        ab = (int'(sb) + int'(pair_line[idx].b) + 2) >> 2;
        ag = (int'(sg) + int'(pair_line[idx].g) + 2) >> 2;
        ar = (int'(sr) + int'(pair_line[idx].r) + 2) >> 2;
        res.chroma_valid = 1'b1;
        res.cb = chroma_of(CB_R, CB_G, CB_B, ar, ag, ab);
        res.cr = chroma_of(CR_R, CR_G, CR_B, ar, ag, ab);
      end
    end
    res.frame_end = (col + 1 == w) && (row + 1 == h);
    if (col + 1 >= w) begin
      col_pos = 0;
      row_pos = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
      row_pos = row;
    end
    return res;
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    ycc_result_t got;
    ycc_result_t want;
    ycc_result_t pred;
    if (!rst_n) begin
      width_reg = RST_FRAME_WIDTH;
      height_reg = RST_FRAME_HEIGHT;
      col_pos = 0;
      row_pos = 0;
      held_b = '0;
      held_g = '0;
      held_r = '0;
      expected_ycc.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (ycc_reg_t'(paddr[2]))
          REG_FRAME_WIDTH:  width_reg = pwdata[SIZE_W-1:0];
          REG_FRAME_HEIGHT: height_reg = pwdata[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) begin
        pred = convert_pixel(pix.blue, pix.green, pix.red);
        expected_ycc = {expected_ycc, pred};
      end
      if (ycc.valid && ycc.ready) begin
        got = {ycc.luma, ycc.chroma_valid, ycc.cb, ycc.cr, ycc.frame_end};
        if (expected_ycc.size() == 0) begin
          mismatches++;
          $display("%0t: result item with none expected, expected nothing, actual %h",
                   $time, got);
        end else begin
          want = expected_ycc.pop_front();
          compare_field("luma", want.luma, got.luma);
          compare_field("chroma_valid", want.chroma_valid, got.chroma_valid);
          compare_field("cb", want.cb, got.cb);
          compare_field("cr", want.cr, got.cr);
          compare_field("frame_end", want.frame_end, got.frame_end);
        end
      end
    end
    outstanding = expected_ycc.size();
  end

endmodule

// ===== tb/rgb_to_ycbcr420_converter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_ycbcr420_converter_tb
// Drives pixels and register writes into the RGB to YCbCr 4:2:0 converter:
// a reset-size row, directed blocks, a size change in mid-frame, oversize
// values and random frames under several idle and stall mixes. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module rgb_to_ycbcr420_converter_tb;
  import ycc_pkg::*;

  localparam int LIMIT_CYCLES  = 500000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_PIXELS  = 60;
  localparam int SEND_IDLE [4] = '{0, 78, 0, 27};
  localparam int RECV_STALL [4] = '{0, 0, 78, 27};

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int mismatches;
  int outstanding;

  ycc_pix_if pix_ch ();
  ycc_out_if ycc_ch ();

  rgb_to_ycbcr420_converter dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_ch),
    .out_ycc (ycc_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rgb_to_ycbcr420_converter_checker checker_i (
    .clk     (clk),
    .rst_n   (rst_n),
    .pix     (pix_ch),
    .ycc     (ycc_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .pready  (pready),
    .errors  (mismatches),
    .pending (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: a requested hold-off wins, else stall at the phase's rate.
  initial begin
    ycc_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        ycc_ch.ready = 1'b0;
        hold_left--;
      end else begin
        ycc_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Offer one pixel, idling first at the phase's rate; hold until accepted.
  // Valid stays high afterwards so back-to-back pixels need no gap.
  task automatic send_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_ch.valid = 1'b0;
      @(negedge clk);
    end
    pix_ch.valid = 1'b1;
    pix_ch.blue  = b;
    pix_ch.green = g;
    pix_ch.red   = r;
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  // Random pixels; about one component in eight sits at an extreme.
  task automatic send_random(input int count);
    logic [PIX_W-1:0] c [3];
    for (int i = 0; i < count; i++) begin
      foreach (c[k]) begin
        if ($urandom_range(7) == 0) c[k] = $urandom_range(1) ? 8'd255 : 8'd0;
        else c[k] = PIX_W'($urandom_range(255));
      end
      send_pixel(c[0], c[1], c[2]);
    end
  endtask

  // Drop valid and wait until every predicted item has come back.
  task automatic drain_results();
    @(negedge clk);
    pix_ch.valid = 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write with a setup and an access phase; junk in the upper data bits must be ignored.
  task automatic write_reg(input ycc_reg_t idx, input logic [SIZE_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = $urandom;
    pwdata[SIZE_W-1:0] = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic resize(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    drain_results();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  initial begin
    int w;
    int h;
    int count;
    int sent;
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    pix_ch.valid = 1'b0;
    pix_ch.blue  = '0;
    pix_ch.green = '0;
    pix_ch.red   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset size: one row of 640 stores 320 pair sums in the line buffer, two more
    // pixels start the odd row and read the first of them back.
    send_random(642);

    // Tiny sizes: one reads as zero after the low bit drops, zero becomes two.
    // The column now sits past the new width and the next row past the new
    // height, so the pixels start at row 0.
    drain_results();
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    write_reg(REG_FRAME_WIDTH, 13'd0);
    repeat (4) send_pixel(8'd0, 8'd0, 8'd0);
    repeat (4) send_pixel(8'd255, 8'd255, 8'd255);
    repeat (4) send_pixel(8'd255, 8'd0, 8'd0);     // highest Cb
    repeat (4) send_pixel(8'd0, 8'd0, 8'd255);     // highest Cr

    // Odd width written; 4x2 with uneven pixels to exercise the rounding.
    resize(13'd5, 13'd2);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd2, 8'd3);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd254, 8'd1, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd127, 8'd129);

    // Size change in mid-frame: stop at column 5 of row 2 of an 8x6 frame,
    // shrink the width so the next pixel starts odd row 3, then shrink the
    // height so row 3 wraps to row 0. Only entries written before are read.
    resize(13'd8, 13'd6);
    send_random(21);
    drain_results();
    write_reg(REG_FRAME_WIDTH, 13'd4);
    send_random(2);
    drain_results();
    write_reg(REG_FRAME_HEIGHT, 13'd2);
    send_random(6);

    // Oversize values saturate to 4096; run a short stretch of row 0 so the
    // next resize may land in mid-row, where only stored entries are read.
    resize(13'h1FFF, 13'h1FFF);
    send_random(8);

    // Random frames under each idle and stall mix.
    for (int p = 0; p < 4; p++) begin
      drain_results();
      send_idle_pct  = SEND_IDLE[p];
      recv_stall_pct = RECV_STALL[p];
      sent = 0;
      while (sent < PHASE_PIXELS) begin
        w = 2 * $urandom_range(1, 8);
        h = 2 * $urandom_range(1, 4);
        resize(SIZE_W'(w + $urandom_range(1)), SIZE_W'(h + $urandom_range(1)));
        count = w * h * $urandom_range(1, 2);
        // Hold the receiver off while pixels keep coming, so the pipe backs up.
        if (sent == 0 && SEND_IDLE[p] == 0) hold_left = HOLD_CYCLES;
        send_random(count);
        sent += count;
      end
    end

    drain_results();
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
